FILE: sv/contiguous_id_range_allocator_core_macros.svh
// assertion macros shared by the allocator rtl
`ifndef CONTIGUOUS_ID_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define CONTIGUOUS_ID_RANGE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CIRA_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CIRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cira_pkg.sv
// shared types and constants of the id range allocator
package cira_pkg;

    localparam int ID_W     = 12;   // identifier and count width
    localparam int RUN_W    = 13;   // run length / extended id width
    localparam int WORD_W   = 8;    // bitmap bits per memory word
    localparam int WBIT_W   = 3;    // bit index width inside a word
    localparam int QDEPTH   = 2;    // command queue entries
    localparam int QPTR_W   = 1;    // command queue pointer width

    // request kinds
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_CLAIM = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;

    // back end operations
    localparam logic [1:0] OP_REPLY = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    typedef struct packed {
        logic [1:0]      op;
        logic            set;
        logic [1:0]      status;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] len;
    } t_cmd;

endpackage

FILE: sv/cira_ram.sv
// generic single-write, single-read ram with registered read data
module cira_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cira_front.sv
// request classifier: checks a request and turns it into a back end command
module cira_front #(
    parameter int SLOTS = 256
) (
    input  logic [1:0]                i_req_type,
    input  logic [cira_pkg::ID_W-1:0] i_list_id,
    input  logic [cira_pkg::ID_W-1:0] i_count,
    output cira_pkg::t_cmd            o_cmd
);

    logic [cira_pkg::RUN_W-1:0] w_sum;
    logic [cira_pkg::ID_W-1:0]  w_hi;
    logic                       w_id_ok;
    logic                       w_cnt_big;

    // last id of a freed range, clipped to the table
    assign w_sum = {1'b0, i_list_id} + {1'b0, i_count} - cira_pkg::RUN_W'(1);
    assign w_hi  = (w_sum >= cira_pkg::RUN_W'(SLOTS)) ? cira_pkg::ID_W'(SLOTS - 1)
                                                     : w_sum[cira_pkg::ID_W-1:0];
    assign w_id_ok   = (i_list_id != '0) &&
                       ({1'b0, i_list_id} < cira_pkg::RUN_W'(SLOTS));
    assign w_cnt_big = {1'b0, i_count} > cira_pkg::RUN_W'(SLOTS);

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = cira_pkg::OP_REPLY;
        o_cmd.status = cira_pkg::ST_OK;
        o_cmd.lo     = i_list_id;
        o_cmd.hi     = i_list_id;
        o_cmd.len    = i_count;
        unique case (i_req_type)
            cira_pkg::REQ_ALLOC: begin
                if (i_count == '0 || w_cnt_big) begin
                    o_cmd.status = cira_pkg::ST_INVALID;
                end else begin
                    o_cmd.op = cira_pkg::OP_SCAN;
                end
            end
            cira_pkg::REQ_FREE: begin
                if (i_list_id == '0 || i_count == '0) begin
                    o_cmd.status = cira_pkg::ST_INVALID;
                end else if (w_id_ok) begin
                    o_cmd.op  = cira_pkg::OP_RANGE;
                    o_cmd.set = 1'b0;
                    o_cmd.hi  = w_hi;
                end
            end
            cira_pkg::REQ_QUERY: begin
                if (w_id_ok) begin
                    o_cmd.op = cira_pkg::OP_QUERY;
                end
            end
            default: begin
                if (!w_id_ok) begin
                    o_cmd.status = cira_pkg::ST_INVALID;
                end else begin
                    o_cmd.op  = cira_pkg::OP_RANGE;
                    o_cmd.set = 1'b1;
                end
            end
        endcase
    end

endmodule

FILE: sv/cira_queue.sv
// short command queue between classifier and bitmap engine
module cira_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cira_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cira_pkg::t_cmd o_cmd
);

    cira_pkg::t_cmd                r_slot [cira_pkg::QDEPTH];
    logic [cira_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [cira_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [cira_pkg::QPTR_W:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (cira_pkg::QPTR_W + 1)'(cira_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

endmodule

FILE: sv/cira_back.sv
// bitmap engine: clearing pass, first-fit scan, range update, query, result register
`include "contiguous_id_range_allocator_core_macros.svh"

module cira_back #(
    parameter int SLOTS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  cira_pkg::t_cmd            i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_clearing,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output logic [1:0]                o_res_status,
    output logic [cira_pkg::ID_W-1:0] o_res_base,
    output logic                      o_res_present
);

    localparam int WORDS = (SLOTS + cira_pkg::WORD_W - 1) / cira_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_QUERY  = 3'd3;
    localparam logic [2:0] S_RMW_RD = 3'd4;
    localparam logic [2:0] S_RMW_WR = 3'd5;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [AW-1:0]                  r_word;
    logic [AW-1:0]                  n_word;
    logic                           r_set;
    logic                           n_set;
    logic [cira_pkg::ID_W-1:0]      r_lo;
    logic [cira_pkg::ID_W-1:0]      n_lo;
    logic [cira_pkg::ID_W-1:0]      r_hi;
    logic [cira_pkg::ID_W-1:0]      n_hi;
    logic [cira_pkg::ID_W-1:0]      r_len;
    logic [cira_pkg::ID_W-1:0]      n_len;
    logic [cira_pkg::ID_W-1:0]      r_base;
    logic [cira_pkg::ID_W-1:0]      n_base;
    logic [cira_pkg::RUN_W-1:0]     r_run;
    logic [cira_pkg::RUN_W-1:0]     n_run;
    logic [cira_pkg::RUN_W-1:0]     r_start;
    logic [cira_pkg::RUN_W-1:0]     n_start;

    logic                           r_out_valid;
    logic [1:0]                     r_out_status;
    logic [cira_pkg::ID_W-1:0]      r_out_base;
    logic                           r_out_present;
    logic                           w_emit;
    logic [1:0]                     w_emit_status;
    logic [cira_pkg::ID_W-1:0]      w_emit_base;
    logic                           w_emit_present;

    logic                           w_pop;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [cira_pkg::WORD_W-1:0]    w_wdata;
    logic [AW-1:0]                  w_raddr;
    logic [cira_pkg::WORD_W-1:0]    w_rdata;

    // scan and mask helpers
    logic [cira_pkg::RUN_W-1:0]     w_run;
    logic [cira_pkg::RUN_W-1:0]     w_start;
    logic                           w_found;
    logic [cira_pkg::ID_W-1:0]      w_base;
    logic [cira_pkg::RUN_W-1:0]     w_bit_id;
    logic                           w_free;
    logic [cira_pkg::ID_W-1:0]      w_mid;
    logic [cira_pkg::WORD_W-1:0]    w_mask;
    logic [cira_pkg::RUN_W-1:0]     w_run_end;
    logic [AW-1:0]                  w_hi_word;

    cira_ram #(
        .WIDTH (cira_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pop     = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_res_ready);
    assign w_hi_word = r_hi[cira_pkg::WBIT_W +: AW];
    assign w_run_end = {1'b0, w_base} + {1'b0, r_len} - cira_pkg::RUN_W'(1);

    // first-fit step over one word, eight slots
    always_comb begin
        w_run    = r_run;
        w_start  = r_start;
        w_found  = 1'b0;
        w_base   = '0;
        w_bit_id = '0;
        w_free   = 1'b0;
        for (int j = 0; j < cira_pkg::WORD_W; j++) begin
            w_bit_id = cira_pkg::RUN_W'({r_word, cira_pkg::WBIT_W'(j)});
            w_free   = !w_rdata[j] && (w_bit_id != '0) &&
                       (w_bit_id < cira_pkg::RUN_W'(SLOTS));
            if (!w_found) begin
                if (!w_free) begin
                    w_run   = '0;
                    w_start = w_bit_id + cira_pkg::RUN_W'(1);
                end else begin
                    w_run = w_run + cira_pkg::RUN_W'(1);
                    if (w_run == {1'b0, r_len}) begin
                        w_found = 1'b1;
                        w_base  = w_start[cira_pkg::ID_W-1:0];
                    end
                end
            end
        end
    end

    // bits of the current word that lie inside [lo, hi]
    always_comb begin
        w_mask = '0;
        w_mid  = '0;
        for (int j = 0; j < cira_pkg::WORD_W; j++) begin
            w_mid     = cira_pkg::ID_W'({r_word, cira_pkg::WBIT_W'(j)});
            w_mask[j] = (w_mid >= r_lo) && (w_mid <= r_hi);
        end
    end

    always_comb begin
        n_state        = r_state;
        n_word         = r_word;
        n_set          = r_set;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_len          = r_len;
        n_base         = r_base;
        n_run          = r_run;
        n_start        = r_start;
        w_we           = 1'b0;
        w_waddr        = r_word;
        w_wdata        = r_set ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
        w_raddr        = '0;
        w_emit         = 1'b0;
        w_emit_status  = cira_pkg::ST_OK;
        w_emit_base    = '0;
        w_emit_present = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                if (r_word == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_IDLE: begin
                w_raddr = (i_cmd.op == cira_pkg::OP_QUERY) ?
                          i_cmd.lo[cira_pkg::WBIT_W +: AW] : '0;
                if (w_pop) begin
                    n_set   = i_cmd.set;
                    n_lo    = i_cmd.lo;
                    n_hi    = i_cmd.hi;
                    n_len   = i_cmd.len;
                    n_base  = '0;
                    n_run   = '0;
                    n_start = cira_pkg::RUN_W'(1);
                    unique case (i_cmd.op)
                        cira_pkg::OP_SCAN: begin
                            n_word  = '0;
                            n_state = S_SCAN;
                        end
                        cira_pkg::OP_RANGE: begin
                            n_word  = i_cmd.lo[cira_pkg::WBIT_W +: AW];
                            n_state = S_RMW_RD;
                        end
                        cira_pkg::OP_QUERY: begin
                            n_word  = i_cmd.lo[cira_pkg::WBIT_W +: AW];
                            n_state = S_QUERY;
                        end
                        default: begin
                            w_emit        = 1'b1;
                            w_emit_status = i_cmd.status;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_raddr = r_word + 1'b1;
                n_run   = w_run;
                n_start = w_start;
                if (w_found) begin
                    n_base  = w_base;
                    n_lo    = w_base;
                    n_hi    = w_run_end[cira_pkg::ID_W-1:0];
                    n_set   = 1'b1;
                    n_word  = w_base[cira_pkg::WBIT_W +: AW];
                    n_state = S_RMW_RD;
                end else if (r_word == AW'(WORDS - 1)) begin
                    w_emit        = 1'b1;
                    w_emit_status = cira_pkg::ST_NOMEM;
                    n_state       = S_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_QUERY: begin
                w_emit         = 1'b1;
                w_emit_present = w_rdata[r_lo[cira_pkg::WBIT_W-1:0]];
                n_state        = S_IDLE;
            end
            S_RMW_RD: begin
                w_raddr = r_word;
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                w_we = 1'b1;
                if (r_word == w_hi_word) begin
                    w_emit      = 1'b1;
                    w_emit_base = r_base;
                    n_state     = S_IDLE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_RMW_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set   <= n_set;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_len   <= n_len;
        r_base  <= n_base;
        r_run   <= n_run;
        r_start <= n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status  <= w_emit_status;
            r_out_base    <= w_emit_base;
            r_out_present <= w_emit_present;
        end
    end

    assign o_cmd_pop     = w_pop;
    assign o_clearing    = (r_state == S_CLEAR);
    assign o_res_valid   = r_out_valid;
    assign o_res_status  = r_out_status;
    assign o_res_base    = r_out_base;
    assign o_res_present = r_out_present;

    `CIRA_ASSERT_HOLDS(a_out_empty_while_busy, i_clk, i_rst_n,
        (r_state != S_IDLE), !r_out_valid, "result pending while an operation runs")
    `CIRA_ASSERT_HOLDS(a_rmw_in_range, i_clk, i_rst_n,
        (r_state == S_RMW_WR), (r_word <= w_hi_word), "update walked past the range")
    `CIRA_ASSERT_HOLDS(a_scan_base_nonzero, i_clk, i_rst_n,
        (r_state == S_SCAN) && w_found, (w_base != '0), "scan returned reserved id")
    `CIRA_ASSERT_NEXT(a_rmw_done_emits, i_clk, i_rst_n,
        (r_state == S_RMW_WR) && (r_word == w_hi_word), r_out_valid,
        "range update finished without a result")

endmodule

FILE: sv/contiguous_id_range_allocator_core.sv
// top level of the first-fit contiguous id range allocator
//
// usage: requests arrive on the s_axis channel, one transaction per request,
// with the request kind in tuser (allocate, free, query, claim) and the id
// and count in tdata. every request gives exactly one result transaction on
// m_axis, in request order, with the status in tuser and base id / present
// flag in tdata.
// operation: a request rejected or answered by the classifier passes only
// through the queue and the result register; a query reads one bitmap word.
// free and claim read and then write each bitmap word touched. allocate
// scans 8-id words up to the end of the first fitting run (ceil(SLOTS/8)
// words at most), then reads and writes each word marked. the bitmap memory
// has one read and one write port and the search loop visits one word per
// cycle; requests are carried out one at a time.
// reset: a clearing pass over all ceil(SLOTS/8) words zeroes the bitmap;
// tready stays low during it.
// stall: a result waits in the output register; the two-entry command queue
// keeps taking requests until it fills, then tready drops.
module contiguous_id_range_allocator_core #(
    parameter int SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // list_id [11:0], count [23:12]
    input  logic [1:0]  i_s_axis_tuser,   // req_type [1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // base_id [11:0], present [12], zero [15:13]
    output logic [1:0]  o_m_axis_tuser    // status [1:0]
);

    cira_pkg::t_cmd             w_front_cmd;
    cira_pkg::t_cmd             w_q_cmd;
    logic                       w_q_full;
    logic                       w_q_valid;
    logic                       w_q_pop;
    logic                       w_push;
    logic                       w_clearing;
    logic [1:0]                 w_res_status;
    logic [cira_pkg::ID_W-1:0]  w_res_base;
    logic                       w_res_present;

    // no requests during the clearing pass or when the queue is full
    assign o_s_axis_tready = !w_q_full && !w_clearing;
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;

    // classify each request as it is accepted
    cira_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_req_type (i_s_axis_tuser),
        .i_list_id  (i_s_axis_tdata[11:0]),
        .i_count    (i_s_axis_tdata[23:12]),
        .o_cmd      (w_front_cmd)
    );

    // decouples acceptance from the bitmap engine
    cira_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // bitmap search and update, owns the result register
    cira_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .i_cmd         (w_q_cmd),
        .o_cmd_pop     (w_q_pop),
        .o_clearing    (w_clearing),
        .o_res_valid   (o_m_axis_tvalid),
        .i_res_ready   (i_m_axis_tready),
        .o_res_status  (w_res_status),
        .o_res_base    (w_res_base),
        .o_res_present (w_res_present)
    );

    // pack the result transaction
    assign o_m_axis_tdata = {3'b000, w_res_present, w_res_base};
    assign o_m_axis_tuser = w_res_status;

endmodule
